// ===== sv/dsrq_pkg.sv =====
// ----------------------------------------------------------------------------
// dsrq_pkg
// Shared types and constants of the deduplicating sound request queue.
// ----------------------------------------------------------------------------
package dsrq_pkg;

   localparam int QUEUE_SLOTS     = 16;
   localparam int ADDR_W          = $clog2(QUEUE_SLOTS);
   localparam int CMD_QUEUE_DEPTH = 2;

   localparam logic [1:0] MODE_ADD   = 2'd0;
   localparam logic [1:0] MODE_DRAIN = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   localparam logic [1:0] STATUS_QUEUED    = 2'd0;
   localparam logic [1:0] STATUS_DUPLICATE = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_PLAY   = 1'b1;

   localparam logic [3:0] CHANNEL_TOP    = 4'd15;
   localparam logic [3:0] LOWEST_DEFAULT = 4'd8;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  sfx_id;
      logic [15:0] rate_scale;
      logic [6:0]  volume;
      logic [11:0] source_pos;
      logic [11:0] camera_inset;
      logic [15:0] base_rate;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  status;
      logic [3:0]  channel;
      logic [7:0]  play_sfx_id;
      logic [17:0] play_frequency;
      logic [6:0]  play_volume;
      logic [6:0]  play_pan;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  sfx_id;
      logic [15:0] rate_scale;
      logic [6:0]  volume;
      logic [6:0]  pan;
      logic [15:0] base_rate;
   } cmd_type;

   typedef struct packed {
      logic [7:0]  sfx_id;
      logic [6:0]  pan;
      logic [15:0] rate_scale;
      logic [6:0]  volume;
      logic [15:0] base_rate;
   } entry_type;

endpackage

// ===== sv/dsrq_front.sv =====
// ----------------------------------------------------------------------------
// dsrq_front
// Accepts request transactions, quantizes the pan and forms queue commands.
// ----------------------------------------------------------------------------
module dsrq_front (
   input  logic              req_valid,
   output logic              req_ready,
   input  dsrq_pkg::req_type req_data,
   input  logic              cmd_full,
   output logic              cmd_push,
   output dsrq_pkg::cmd_type cmd_data
);

   localparam logic signed [12:0] PAN_EDGE_0 = 13'sd32;
   localparam logic signed [12:0] PAN_EDGE_1 = 13'sd96;
   localparam logic signed [12:0] PAN_EDGE_2 = 13'sd160;
   localparam logic signed [12:0] PAN_EDGE_3 = 13'sd244;

   logic signed [12:0] diff;
   logic [6:0]         pan;
   logic               known_mode;

   assign diff = $signed({1'b0, req_data.source_pos})
               - $signed({1'b0, req_data.camera_inset});

   always_comb begin
      if (diff < PAN_EDGE_0) begin
         pan = 7'd0;
      end else if (diff < PAN_EDGE_1) begin
         pan = 7'd32;
      end else if (diff < PAN_EDGE_2) begin
         pan = 7'd64;
      end else if (diff < PAN_EDGE_3) begin
         pan = 7'd95;
      end else begin
         pan = 7'd127;
      end
   end

   // unused mode code is taken and discarded
   assign known_mode = (req_data.mode == dsrq_pkg::MODE_ADD)
                    || (req_data.mode == dsrq_pkg::MODE_DRAIN)
                    || (req_data.mode == dsrq_pkg::MODE_CLEAR);

   assign req_ready = !cmd_full;
   assign cmd_push  = req_valid && !cmd_full && known_mode;

   always_comb begin
      cmd_data.op         = req_data.mode;
      cmd_data.sfx_id     = req_data.sfx_id;
      cmd_data.rate_scale = req_data.rate_scale;
      cmd_data.volume     = req_data.volume;
      cmd_data.pan        = pan;
      cmd_data.base_rate  = req_data.base_rate;
   end

endmodule

// ===== sv/dsrq_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// dsrq_cmd_fifo
// Short command queue between the front and back sections.
// ----------------------------------------------------------------------------
module dsrq_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  dsrq_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              pop_valid,
   output dsrq_pkg::cmd_type pop_data
);

   localparam int DEPTH = dsrq_pkg::CMD_QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   dsrq_pkg::cmd_type slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/dsrq_back.sv =====
// ----------------------------------------------------------------------------
// dsrq_back
// Executes queue commands: duplicate search and insert, drain, clear.
// ----------------------------------------------------------------------------
module dsrq_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [3:0]        lowest_channel,
   input  logic              cmd_valid,
   input  dsrq_pkg::cmd_type cmd_data,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dsrq_pkg::rsp_type rsp_data
);

   localparam int AW = dsrq_pkg::ADDR_W;
   localparam logic [AW-1:0] LAST_SLOT = AW'(dsrq_pkg::QUEUE_SLOTS - 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CHECK  = 5'b00010,
      ST_STATUS = 5'b00100,
      ST_FETCH  = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [AW-1:0]       idx_ff, idx_in;
   logic [AW-1:0]       count_ff, count_in;
   logic [3:0]          chan_ff, chan_in;
   logic [1:0]          status_ff, status_in;
   dsrq_pkg::cmd_type   cmd_ff, cmd_in;
   logic                rsp_valid_ff, rsp_valid_in;
   dsrq_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   dsrq_pkg::entry_type store [dsrq_pkg::QUEUE_SLOTS];
   dsrq_pkg::entry_type rd_data_ff;
   dsrq_pkg::entry_type wr_entry;
   logic [31:0]         prod_ff;
   logic                wr_en;
   logic                out_free;
   logic                match;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign match = (rd_data_ff.sfx_id == cmd_ff.sfx_id)
               && (rd_data_ff.pan == cmd_ff.pan)
               && (rd_data_ff.rate_scale == cmd_ff.rate_scale)
               && (rd_data_ff.volume == cmd_ff.volume);

   always_comb begin
      wr_entry.sfx_id     = cmd_in.sfx_id;
      wr_entry.pan        = cmd_in.pan;
      wr_entry.rate_scale = cmd_in.rate_scale;
      wr_entry.volume     = cmd_in.volume;
      wr_entry.base_rate  = cmd_in.base_rate;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      chan_in      = chan_ff;
      status_in    = status_ff;
      cmd_in       = cmd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      cmd_pop      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd_data;
               idx_in  = '0;
               case (cmd_data.op)
                  dsrq_pkg::MODE_ADD: begin
                     if (count_ff == LAST_SLOT) begin
                        status_in = dsrq_pkg::STATUS_FULL;
                        state_in  = ST_STATUS;
                     end else if (count_ff == '0) begin
                        wr_en     = 1'b1;
                        count_in  = count_ff + AW'(1);
                        status_in = dsrq_pkg::STATUS_QUEUED;
                        state_in  = ST_STATUS;
                     end else begin
                        state_in = ST_CHECK;
                     end
                  end
                  dsrq_pkg::MODE_DRAIN: begin
                     if (count_ff != '0) begin
                        state_in = ST_FETCH;
                     end
                  end
                  dsrq_pkg::MODE_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CHECK: begin
            if (match) begin
               status_in = dsrq_pkg::STATUS_DUPLICATE;
               state_in  = ST_STATUS;
            end else if (idx_ff == count_ff - AW'(1)) begin
               wr_en     = 1'b1;
               count_in  = count_ff + AW'(1);
               status_in = dsrq_pkg::STATUS_QUEUED;
               state_in  = ST_STATUS;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_data_in        = '0;
               rsp_data_in.kind   = dsrq_pkg::KIND_STATUS;
               rsp_data_in.status = status_ff;
               state_in           = ST_IDLE;
            end
         end
         ST_FETCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.kind           = dsrq_pkg::KIND_PLAY;
               rsp_data_in.status         = dsrq_pkg::STATUS_QUEUED;
               rsp_data_in.channel        = chan_ff;
               rsp_data_in.play_sfx_id    = rd_data_ff.sfx_id;
               rsp_data_in.play_frequency = prod_ff[31:14];
               rsp_data_in.play_volume    = rd_data_ff.volume;
               rsp_data_in.play_pan       = rd_data_ff.pan;
               rsp_data_in.last           = (idx_ff == count_ff - AW'(1));
               chan_in = (chan_ff <= lowest_channel) ? dsrq_pkg::CHANNEL_TOP
                                                     : chan_ff - 4'd1;
               if (idx_ff == count_ff - AW'(1)) begin
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         chan_ff      <= dsrq_pkg::CHANNEL_TOP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chan_ff      <= chan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      status_ff   <= status_in;
      cmd_ff      <= cmd_in;
      rsp_data_ff <= rsp_data_in;
      prod_ff     <= {16'd0, rd_data_ff.base_rate} * {16'd0, rd_data_ff.rate_scale};
   end

   // entry store, read address follows the scan index
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[count_ff] <= wr_entry;
      end
      rd_data_ff <= store[idx_in];
   end

endmodule

// ===== sv/dedup_sound_request_queue_top.sv =====
// ----------------------------------------------------------------------------
// dedup_sound_request_queue_top
// Sound request queue with duplicate suppression, pan quantization and
// channel rotation on drain.
// ----------------------------------------------------------------------------
// add: status once the queued entries are scanned one per cycle, up to the first duplicate
// drain: each queued entry is read in FETCH, then sent as a play command in EMIT
// clear: drops all; a command queue of two lets the front accept while the back works
// reset is synchronous: queue empty, channel 15, lowest channel 8, store not cleared
// ----------------------------------------------------------------------------
module dedup_sound_request_queue_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dsrq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dsrq_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [3:0]        csr_data
);

   logic              cmd_full;
   logic              cmd_push;
   dsrq_pkg::cmd_type cmd_push_data;
   logic              cmd_pop;
   logic              cmd_valid;
   dsrq_pkg::cmd_type cmd_pop_data;
   logic [3:0]        lowest_ff, lowest_in;

   assign csr_ready = 1'b1;
   assign lowest_in = (csr_valid && csr_ready) ? csr_data : lowest_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lowest_ff <= dsrq_pkg::LOWEST_DEFAULT;
      end else begin
         lowest_ff <= lowest_in;
      end
   end

   dsrq_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd_full  (cmd_full),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_push_data)
   );

   dsrq_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_valid (cmd_valid),
      .pop_data  (cmd_pop_data)
   );

   dsrq_back u_back (
      .clock          (clock),
      .reset          (reset),
      .lowest_channel (lowest_ff),
      .cmd_valid      (cmd_valid),
      .cmd_data       (cmd_pop_data),
      .cmd_pop        (cmd_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data)
   );

endmodule

// ===== tb/sv/dedup_sound_request_queue_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dedup_sound_request_queue_checker
// Watches the request, response and register channels of the sound request
// queue, keeps its own copy of the queue, the channel rotation and the lowest
// channel, and checks every response transaction field by field in order.
// ----------------------------------------------------------------------------
module dedup_sound_request_queue_checker
   import dsrq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  rsp_type    rsp_data,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [3:0] csr_data,
   output int         failures,
   output int         outstanding
);

   entry_type   queued_sounds [QUEUE_SLOTS];
   int unsigned sound_count;
   logic [3:0]  play_channel;
   logic [3:0]  lowest_channel;
   rsp_type     due_responses [$];
   int          fail_count = 0;

   assign failures = fail_count;

   function automatic logic [6:0] pan_of(input logic [11:0] loc, input logic [11:0] cam);
      int d;
      d = int'(loc) - int'(cam);
      if (d < 32) return 7'd0;
      if (d < 96) return 7'd32;
      if (d < 160) return 7'd64;
      if (d < 244) return 7'd95;
      return 7'd127;
   endfunction

   function automatic void check_field(input string field, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         fail_count++;
      end
   endfunction

   task automatic apply_request(input req_type r);
      entry_type   fresh;
      rsp_type     answer;
      logic [31:0] product;
      int          ch;
      fresh = '{sfx_id: r.sfx_id, pan: pan_of(r.source_pos, r.camera_inset),
                rate_scale: r.rate_scale, volume: r.volume,
                base_rate: r.base_rate};
      answer = '0;
      case (r.mode)
         MODE_ADD: begin
            answer.kind = KIND_STATUS;
            answer.status = STATUS_QUEUED;
            if (sound_count >= QUEUE_SLOTS - 1) begin
               answer.status = STATUS_FULL;
            end else begin
               for (int i = 0; i < sound_count; i++) begin
                  if (queued_sounds[i].sfx_id == fresh.sfx_id &&
                      queued_sounds[i].pan == fresh.pan &&
                      queued_sounds[i].rate_scale == fresh.rate_scale &&
                      queued_sounds[i].volume == fresh.volume) begin
                     answer.status = STATUS_DUPLICATE;
                     break;
                  end
               end
               if (answer.status == STATUS_QUEUED) begin
                  queued_sounds[sound_count] = fresh;
                  sound_count++;
               end
            end
            due_responses.push_back(answer);
         end
         MODE_DRAIN: begin
            for (int i = 0; i < sound_count; i++) begin
               product = {16'd0, queued_sounds[i].base_rate} *
                         {16'd0, queued_sounds[i].rate_scale};
               answer = '0;
               answer.kind = KIND_PLAY;
               answer.channel = play_channel;
               answer.play_sfx_id = queued_sounds[i].sfx_id;
               answer.play_frequency = product[31:14];
               answer.play_volume = queued_sounds[i].volume;
               answer.play_pan = queued_sounds[i].pan;
               answer.last = (i + 1 == sound_count);
               due_responses.push_back(answer);
               ch = int'(play_channel) - 1;
               if (ch < int'(lowest_channel)) ch = int'(CHANNEL_TOP);
               play_channel = ch[3:0];
            end
            sound_count = 0;
         end
         MODE_CLEAR: begin
            sound_count = 0;
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         sound_count = 0;
         play_channel = CHANNEL_TOP;
         lowest_channel = LOWEST_DEFAULT;
         due_responses.delete();
      end else begin
         if (csr_valid && csr_ready) lowest_channel = csr_data;
         if (req_valid && req_ready) apply_request(req_data);
         if (rsp_valid && rsp_ready) begin
            if (due_responses.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h", $time, rsp_data);
               fail_count++;
            end else begin
               want = due_responses.pop_front();
               check_field("kind", want.kind, rsp_data.kind);
               check_field("status", want.status, rsp_data.status);
               check_field("channel", want.channel, rsp_data.channel);
               check_field("play_sfx_id", want.play_sfx_id, rsp_data.play_sfx_id);
               check_field("play_frequency", want.play_frequency, rsp_data.play_frequency);
               check_field("play_volume", want.play_volume, rsp_data.play_volume);
               check_field("play_pan", want.play_pan, rsp_data.play_pan);
               check_field("last", want.last, rsp_data.last);
            end
         end
      end
      outstanding <= due_responses.size();
   end

endmodule

// ===== tb/sv/dedup_sound_request_queue_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dedup_sound_request_queue_top_test
// Drives add, drain, clear and unused requests into the sound request queue
// under several lowest channel settings, with random gaps and response
// stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module dedup_sound_request_queue_top_test;
   import dsrq_pkg::*;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [3:0] csr_data = '0;
   int         failures;
   int         outstanding;
   int         sent_items = 0;
   bit         calm = 1'b0;

   dedup_sound_request_queue_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   dedup_sound_request_queue_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("DONE: errors detected");
      $finish;
   end

   // response side stalls
   initial begin
      @(posedge clock);
      forever begin
         if (calm) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   function automatic req_type make_add(input logic [7:0] kind_id, input logic [15:0] rel,
                                        input logic [6:0] vol, input logic [11:0] loc,
                                        input logic [11:0] cam, input logic [15:0] nat);
      return '{mode: MODE_ADD, sfx_id: kind_id, rate_scale: rel, volume: vol,
               source_pos: loc, camera_inset: cam, base_rate: nat};
   endfunction

   function automatic req_type misc_item(input logic [1:0] mode);
      return '{mode: mode, sfx_id: 8'($urandom), rate_scale: 16'($urandom),
               volume: 7'($urandom), source_pos: 12'($urandom),
               camera_inset: 12'($urandom), base_rate: 16'($urandom)};
   endfunction

   function automatic req_type random_add();
      logic [11:0] cam;
      logic [11:0] loc;
      cam = 12'($urandom);
      case ($urandom_range(0, 2))
         0: loc = 12'($urandom);
         1: loc = cam + 12'($urandom_range(0, 300));
         default: loc = cam - 12'($urandom_range(0, 40));
      endcase
      return make_add(8'($urandom), 16'($urandom), 7'($urandom), loc, cam, 16'($urandom));
   endfunction

   task automatic push_request(input req_type r);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      sent_items++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_lowest(input logic [3:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic run_burst();
      req_type recent [$];
      req_type r;
      int      adds;
      adds = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 19) : $urandom_range(1, 14);
      for (int i = 0; i < adds; i++) begin
         if (recent.size() != 0 && $urandom_range(0, 3) == 0) begin
            r = recent[$urandom_range(0, recent.size() - 1)];
            r.base_rate = 16'($urandom);
         end else begin
            r = random_add();
         end
         if ($urandom_range(0, 24) == 0) push_request(misc_item(2'($urandom_range(1, 3))));
         push_request(r);
         recent.push_back(r);
      end
      push_request(misc_item(($urandom_range(0, 4) == 0) ? MODE_CLEAR : MODE_DRAIN));
   endtask

   initial begin : stimulus
      logic [3:0] lowest_plan [6];
      int         goal;
      int         waited;
      lowest_plan = '{4'd0, 4'd15, 4'd4, 4'd1, 4'($urandom), LOWEST_DEFAULT};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part with the lowest channel at its reset value
      push_request(misc_item(MODE_DRAIN));
      push_request(make_add(8'd0, 16'd0, 7'd0, 12'd0, 12'd0, 16'd0));
      push_request(make_add(8'd255, 16'hFFFF, 7'd127, 12'd4095, 12'd0, 16'hFFFF));
      push_request(make_add(8'd255, 16'hFFFF, 7'd127, 12'd4000, 12'd100, 16'd1234));
      push_request(make_add(8'd10, 16'd16384, 7'd64, 12'd131, 12'd100, 16'd22050));
      push_request(make_add(8'd11, 16'd16384, 7'd64, 12'd132, 12'd100, 16'd22050));
      push_request(make_add(8'd12, 16'd16384, 7'd64, 12'd195, 12'd100, 16'd11025));
      push_request(make_add(8'd13, 16'd16384, 7'd64, 12'd196, 12'd100, 16'd11025));
      push_request(make_add(8'd14, 16'd32768, 7'd64, 12'd259, 12'd100, 16'd8000));
      push_request(make_add(8'd15, 16'd8192, 7'd64, 12'd260, 12'd100, 16'd8000));
      push_request(make_add(8'd16, 16'd16384, 7'd1, 12'd343, 12'd100, 16'd44100));
      push_request(make_add(8'd17, 16'd16384, 7'd1, 12'd344, 12'd100, 16'd44100));
      push_request(make_add(8'd18, 16'd16384, 7'd64, 12'd0, 12'd4095, 16'd500));
      push_request(make_add(8'd10, 16'd16384, 7'd64, 12'd5, 12'd3000, 16'd777));
      push_request(misc_item(MODE_SPARE));
      push_request(misc_item(MODE_DRAIN));
      push_request(random_add());
      push_request(random_add());
      push_request(misc_item(MODE_CLEAR));
      push_request(misc_item(MODE_DRAIN));
      settle();

      goal = sent_items;
      foreach (lowest_plan[p]) begin
         write_lowest(lowest_plan[p]);
         if (p == 5) calm = 1'b1;
         goal += 36;
         while (sent_items < goal) run_burst();
         settle();
      end

      waited = 0;
      while (outstanding != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
